// ===== rtl/gofs_pkg.sv =====
package gofs_pkg;

    localparam int WORD_W = 64;
    localparam int MW_W   = 7;
    localparam int SIZE_W = 10;

    localparam logic [MW_W-1:0] MIRROR_WIDTH_RESET = 7'd49;
    localparam logic [MW_W-1:0] MIRROR_WIDTH_MAX   = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_MIRROR_WIDTH = 1'b0;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } cand_t;

    // true when the word has three or more set bits
    function automatic logic overlap_three(input logic [WORD_W-1:0] n);
        logic [WORD_W-1:0] n1;
        logic [WORD_W-1:0] n2;
        n1 = n & (n - WORD_W'(1));
        n2 = n1 & (n1 - WORD_W'(1));
        return |n2;
    endfunction

    // low mw bits reversed, widths above 64 treated as 64
    function automatic logic [WORD_W-1:0] mirror_word(input logic [WORD_W-1:0] w,
                                                      input logic [MW_W-1:0]   mw);
        logic [WORD_W-1:0] rev;
        logic [MW_W-1:0]   w_eff;
        logic [MW_W-1:0]   sh;
        for (int i = 0; i < WORD_W; i++) begin
            rev[i] = w[WORD_W-1-i];
        end
        w_eff = (mw > MIRROR_WIDTH_MAX) ? MIRROR_WIDTH_MAX : mw;
        sh    = MIRROR_WIDTH_MAX - w_eff;
        return rev >> sh;
    endfunction

endpackage

// ===== rtl/gofs_ram.sv =====
module gofs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gofs_front.sv =====
module gofs_front
    import gofs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_combination,
    input  logic [MW_W-1:0]   mirror_width,
    input  logic              q_full,
    output logic              q_push,
    output cand_t             q_push_data
);

    logic              busy_reg;
    logic              phase_reg;
    logic [WORD_W-1:0] word_reg;

    assign s_ready = !busy_reg;
    assign q_push  = busy_reg && !q_full;

    always_comb begin
        if (phase_reg) begin
            q_push_data.word = mirror_word(word_reg, mirror_width);
            q_push_data.last = 1'b1;
        end else begin
            q_push_data.word = word_reg;
            q_push_data.last = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
        end else if (q_push) begin
            busy_reg  <= !phase_reg;
            phase_reg <= !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_combination;
        end
    end

endmodule

// ===== rtl/gofs_queue.sv =====
module gofs_queue
    import gofs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  cand_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output cand_t pop_data
);

    localparam logic [1:0] CNT_FULL = 2'd2;

    cand_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (cnt_reg == CNT_FULL);
    assign valid    = (cnt_reg != 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/gofs_back.sv =====
module gofs_back
    import gofs_pkg::*;
#(
    parameter int CAPACITY = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cand_t             q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_tested_word,
    output logic              m_accepted,
    output logic              m_store_full,
    output logic [SIZE_W-1:0] m_set_size,
    output logic              m_last_of_pair
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_REPORT = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    cand_t             cand_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              clash_reg;
    logic [WORD_W-1:0] and_reg;
    logic [WORD_W-1:0] rdata;
    logic              issue;
    logic              scan_done;
    logic              out_free;
    logic              room;
    logic              append;
    logic              report;
    logic [CNT_W-1:0]  count_next;

    assign issue     = (state_reg == ST_SCAN) && !clash_reg && (idx_reg != count_reg);
    assign scan_done = (clash_reg || (idx_reg == count_reg)) && !v1_reg && !v2_reg;
    assign out_free  = !m_valid || m_ready;
    assign room      = (count_reg != CAP_CNT);
    assign report    = (state_reg == ST_REPORT) && out_free;
    assign append    = report && !clash_reg && room;
    assign count_next = append ? count_reg + CNT_W'(1) : count_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    gofs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (append),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (cand_reg.word),
        .re    (issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            clash_reg <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (q_pop) begin
                idx_reg   <= '0;
                clash_reg <= 1'b0;
            end else begin
                if (issue) begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (v2_reg && overlap_three(and_reg)) begin
                    clash_reg <= 1'b1;
                end
            end
            if (report) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cand_reg <= q_data;
        end
        and_reg <= rdata & cand_reg.word;
        if (report) begin
            m_tested_word  <= cand_reg.word;
            m_accepted     <= !clash_reg && room;
            m_store_full   <= !clash_reg && !room;
            m_set_size     <= SIZE_W'(count_next);
            m_last_of_pair <= cand_reg.last;
        end
    end

endmodule

// ===== rtl/greedy_overlap_filter_set_core.sv =====
// channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------
// input     | s_valid / s_ready           | s_combination
// result    | m_valid / m_ready           | m_tested_word, m_accepted, m_store_full,
//           |                             | m_set_size, m_last_of_pair
// config    | psel, penable, pwrite/pready| paddr, pwdata, prdata (mirror_width at 0)
//
// each item gives two results, the word then its mirror
// each candidate holds the back part while the entries held are scanned
// the scan stops early once a conflict is seen
// reset empties the set and loads mirror_width with 49, no clearing pass
// front and back stall on their own through a two-entry candidate queue
module greedy_overlap_filter_set_core
    import gofs_pkg::*;
#(
    parameter int CAPACITY = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_combination,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_tested_word,
    output logic              m_accepted,
    output logic              m_store_full,
    output logic [SIZE_W-1:0] m_set_size,
    output logic              m_last_of_pair,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [MW_W-1:0] mirror_width_reg;
    logic            q_full;
    logic            q_push;
    cand_t           q_push_data;
    logic            q_pop;
    logic            q_valid;
    cand_t           q_pop_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIRROR_WIDTH) ? 32'(mirror_width_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_width_reg <= MIRROR_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIRROR_WIDTH) begin
            mirror_width_reg <= pwdata[MW_W-1:0];
        end
    end

    gofs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_combination (s_combination),
        .mirror_width  (mirror_width_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    gofs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    gofs_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tested_word  (m_tested_word),
        .m_accepted     (m_accepted),
        .m_store_full   (m_store_full),
        .m_set_size     (m_set_size),
        .m_last_of_pair (m_last_of_pair)
    );

endmodule

// ===== tb/sv/tb_greedy_overlap_filter_set_core.sv =====
module tb_greedy_overlap_filter_set_core;
    import gofs_pkg::*;

    localparam int CAPACITY = 512;
    localparam int LIMIT    = 4_000_000;
    localparam logic [2:0] MIRROR_WIDTH_ADDR = {REG_MIRROR_WIDTH, 2'b00};

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              accepted;
        logic              store_full;
        logic [SIZE_W-1:0] set_size;
        logic              last_of_pair;
    } verdict_t;

    class overlap_set_tracker;
        logic [WORD_W-1:0] words [CAPACITY];
        int unsigned       count;
        logic [MW_W-1:0]   mirror_w;
        verdict_t          verdicts [$];
        int                errors;
        int                items;
        int                checked;
        int                n_added;
        int                n_clash;
        int                n_full;

        function new();
            count    = 0;
            mirror_w = MIRROR_WIDTH_RESET;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        function logic [WORD_W-1:0] mirror_of(logic [WORD_W-1:0] w);
            logic [WORD_W-1:0] r;
            int unsigned       n;
            n = (mirror_w > 64) ? 64 : mirror_w;
            r = '0;
            for (int i = 0; i < n; i++) r[n-1-i] = w[i];
            return r;
        endfunction

        function verdict_t screen(logic [WORD_W-1:0] cand, logic last_flag);
            verdict_t v;
            bit       clash;
            clash = 1'b0;
            for (int i = 0; i < count; i++) begin
                if ($countones(words[i] & cand) >= 3) begin
                    clash = 1'b1;
                    break;
                end
            end
            v.word         = cand;
            v.accepted     = 1'b0;
            v.store_full   = 1'b0;
            v.last_of_pair = last_flag;
            if (clash) begin
                n_clash++;
            end else if (count < CAPACITY) begin
                words[count] = cand;
                count++;
                v.accepted = 1'b1;
                n_added++;
            end else begin
                v.store_full = 1'b1;
                n_full++;
            end
            v.set_size = SIZE_W'(count);
            return v;
        endfunction

        function void note_combination(logic [WORD_W-1:0] w);
            verdict_t v;
            items++;
            v = screen(w, 1'b0);
            verdicts.insert(verdicts.size(), v);
            v = screen(mirror_of(w), 1'b1);
            verdicts.insert(verdicts.size(), v);
        endfunction

        task check_verdict(verdict_t got);
            verdict_t want;
            if (verdicts.size() == 0) begin
                report($sformatf("result with nothing expected, word %h", got.word));
                return;
            end
            want = verdicts.pop_front();
            checked++;
            if (got.word !== want.word)
                report($sformatf("tested_word got %h want %h", got.word, want.word));
            if (got.accepted !== want.accepted)
                report($sformatf("accepted got %b want %b, word %h",
                                 got.accepted, want.accepted, want.word));
            if (got.store_full !== want.store_full)
                report($sformatf("store_full got %b want %b, word %h",
                                 got.store_full, want.store_full, want.word));
            if (got.set_size !== want.set_size)
                report($sformatf("set_size got %0d want %0d, word %h",
                                 got.set_size, want.set_size, want.word));
            if (got.last_of_pair !== want.last_of_pair)
                report($sformatf("last_of_pair got %b want %b, word %h",
                                 got.last_of_pair, want.last_of_pair, want.word));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [WORD_W-1:0] s_combination;
    logic              m_valid;
    logic              m_ready;
    logic [WORD_W-1:0] m_tested_word;
    logic              m_accepted;
    logic              m_store_full;
    logic [SIZE_W-1:0] m_set_size;
    logic              m_last_of_pair;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    overlap_set_tracker sb = new();
    verdict_t           got_v;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 long_hold_cycles = 0;
    string              widths_used = "";

    greedy_overlap_filter_set_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_combination (s_combination),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tested_word (m_tested_word),
        .m_accepted    (m_accepted),
        .m_store_full  (m_store_full),
        .m_set_size    (m_set_size),
        .m_last_of_pair(m_last_of_pair),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_combination(s_combination);
            if (m_valid && m_ready) begin
                got_v = {m_tested_word, m_accepted, m_store_full, m_set_size, m_last_of_pair};
                sb.check_verdict(got_v);
            end
        end
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold_cycles > 0) begin
                m_ready <= 1'b0;
                long_hold_cycles--;
            end else begin
                m_ready <= !roll(recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [WORD_W-1:0] w);
        @(negedge aclk);
        while (roll(send_idle_pct)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_combination <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mirror_width_reg();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MIRROR_WIDTH_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {25'd0, sb.mirror_w})
            sb.report($sformatf("mirror_width read %h want %h", prdata, sb.mirror_w));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only called with the input channel quiet
    task automatic set_mirror_width(input logic [31:0] value);
        wait_drained();
        repeat (8) @(posedge aclk);
        apb_write(MIRROR_WIDTH_ADDR, value);
        sb.mirror_w = value[MW_W-1:0];
        widths_used = {widths_used, $sformatf(" %0d", sb.mirror_w)};
        check_mirror_width_reg();
    endtask

    function automatic logic [WORD_W-1:0] pick_bits(int unsigned width, int unsigned k);
        logic [WORD_W-1:0] w;
        w = '0;
        if (k > width) k = width;
        while ($countones(w) < k) w[$urandom_range(0, width - 1)] = 1'b1;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] next_combination();
        int unsigned ew;
        int unsigned pick;
        ew   = (sb.mirror_w == 0 || sb.mirror_w > 64) ? 64 : sb.mirror_w;
        pick = $urandom_range(0, 99);
        if (pick < 35) return pick_bits(ew, $urandom_range(3, 8));
        if (pick < 75) return pick_bits(64, $urandom_range(0, 2));
        if (pick < 85 || sb.count == 0) return {$urandom, $urandom};
        if (pick < 95) return sb.words[$urandom_range(0, sb.count - 1)];
        return sb.mirror_of(sb.words[$urandom_range(0, sb.count - 1)]);
    endfunction

    task automatic run_segment(input int n, input int s_pct, input int r_pct,
                               input bit hold_first, input bit drain_midway);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (hold_first) long_hold_cycles = 600;
        for (int i = 0; i < n; i++) begin
            if (drain_midway && i == n / 2) begin
                stop_sending();
                wait_drained();
            end
            send_item(next_combination());
        end
        stop_sending();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_combination = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        check_mirror_width_reg();
        send_idle_pct = 37;
        recv_idle_pct = 68;

        // reset width: empty word, overlap of exactly two and three, all ones
        send_item(64'h0);
        send_item(64'h7);
        send_item(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'h7);
        send_item(64'h3);
        send_item(64'h8000_0000_0000_0001);
        send_item(64'h0001_2100_4010_0400);
        send_item(64'h0001_0000_0000_0000);
        stop_sending();

        // zero width gives an empty mirror
        set_mirror_width(32'd0);
        send_item(64'h0123_4567_89AB_CDEF);
        send_item(64'h8);
        stop_sending();

        // widths above 64 act as 64
        set_mirror_width(32'd127);
        send_item(64'h8000_0000_0000_0000);
        send_item(64'hA5A5_A5A5_A5A5_A5A5);
        stop_sending();

        set_mirror_width(32'd64);
        send_item(64'h1);
        send_item(64'hFFFF_FFFF_0000_0000);
        stop_sending();

        set_mirror_width(32'd1);
        send_item(64'h5);
        send_item(64'hFFFF_FFFF_FFFF_FFFE);
        stop_sending();

        // upper data bits are dropped
        set_mirror_width(32'hFFFF_FF80 | 32'd49);
        send_item(64'h0001_0000_0000_0003);
        stop_sending();

        run_segment(94, 37, 68, 1'b0, 1'b0);
        set_mirror_width(32'd64);
        run_segment(94, 37, 68, 1'b1, 1'b0);
        set_mirror_width($urandom_range(2, 63));
        run_segment(94, 68, 37, 1'b0, 1'b0);
        set_mirror_width(32'd127);
        run_segment(94, 68, 37, 1'b0, 1'b1);
        set_mirror_width(32'd49);
        run_segment(94, 0, 0, 1'b0, 1'b0);
        set_mirror_width($urandom_range(1, 64));
        run_segment(94, 0, 0, 1'b0, 1'b0);

        wait_drained();
        repeat (50) @(posedge aclk);
        if (sb.verdicts.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.verdicts.size()));

        $display("run covered %0d items and %0d results: %0d added, %0d conflicts, %0d full",
                 sb.items, sb.checked, sb.n_added, sb.n_clash, sb.n_full);
        $display("mirror widths written:%s, set ends with %0d of %0d entries",
                 widths_used, sb.count, CAPACITY);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
